@@ sv/sdd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdd_pkg: shared types and constants for the stream duplicate detector
// Hash multiplier, key and epoch widths, default table size, sequencer states.
// ----------------------------------------------------------------------------
package sdd_pkg;

    localparam int unsigned KEY_W             = 32;
    localparam int unsigned EPOCH_W           = 8;
    localparam int unsigned TABLE_ENTRIES_DEF = 1024;
    localparam logic [KEY_W-1:0] HASH_MULT    = 32'd2654435761;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } sdd_state_t;

endpackage

@@ sv/sdd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sdd_ram #(
    parameter int unsigned WIDTH = 40,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/stream_duplicate_detector_top.sv @@
`timescale 1ns / 1ps
// Each accepted element is hashed and then probed (P probes, P >= 1) before ready returns,
// with a reciprocal slot reduction after the hash when TABLE_ENTRIES is not a power of two.
// No new element is taken before the last one is done; each probe costs one RAM read
// and one compare. The result is registered when the final element is done.
// Reset (synchronous, active low) starts a clearing pass over every entry of the slot
// RAM; the same pass runs again after every 255th array as the epoch counter wraps.
// ----------------------------------------------------------------------------
// stream_duplicate_detector_top: hash-set duplicate detector
// Open addressing with linear probing; slot validity held as an epoch tag in RAM.
// ----------------------------------------------------------------------------
module stream_duplicate_detector_top
    import sdd_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic signed [KEY_W-1:0] s_value,
    input  logic                    s_last,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_has_duplicate,
    output logic                    m_table_overflow,
    output logic                    m_valid,
    input  logic                    m_ready
);

    localparam int unsigned IW     = $clog2(TABLE_ENTRIES);
    localparam int unsigned WORD_W = EPOCH_W + KEY_W;
    localparam int unsigned PROD_W = 2 * KEY_W;
    localparam int unsigned CNT_W  = 2;
    localparam bit          IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
    localparam int unsigned RECIP_SHIFT = KEY_W + IW;
    localparam int unsigned Q_SHIFT     = 16 + IW;
    localparam logic [63:0] RECIP = (64'd1 << RECIP_SHIFT) / 64'(TABLE_ENTRIES);
    localparam logic [KEY_W-1:0] RECIP_LO = KEY_W'(RECIP[15:0]);
    localparam logic [KEY_W-1:0] RECIP_HI = KEY_W'(RECIP[32:16]);
    localparam logic [KEY_W-1:0] N_K      = KEY_W'(TABLE_ENTRIES);
    localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] MOD_LO  = CNT_W'(0);
    localparam logic [CNT_W-1:0] MOD_HI  = CNT_W'(1);
    localparam logic [CNT_W-1:0] MOD_MUL = CNT_W'(2);
    localparam logic [CNT_W-1:0] MOD_FIX = CNT_W'(3);
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    sdd_state_t state_reg, state_next;

    logic [KEY_W-1:0]   key_reg, key_next;
    logic               last_reg, last_next;
    logic [KEY_W-1:0]   prod_reg, prod_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [IW-1:0]      step_reg, step_next;
    logic [IW-1:0]      clr_reg, clr_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic               found_reg, found_next;
    logic               ovf_reg, ovf_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_dup_reg, m_dup_next;
    logic               m_ovf_reg, m_ovf_next;

    logic [KEY_W-1:0]   mul_a;
    logic [KEY_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [KEY_W-1:0]   product;
    logic [KEY_W-1:0]   rem_fix;
    logic               slot_valid;
    logic               key_match;
    logic               emit_ok;
    logic [IW-1:0]      idx_inc;

    logic               ram_wr_en;
    logic [IW-1:0]      ram_wr_addr;
    logic [WORD_W-1:0]  ram_wr_data;
    logic               ram_rd_en;
    logic [WORD_W-1:0]  ram_rd_data;

    sdd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // shared multiplier operands
    always_comb begin
        mul_a = key_reg;
        mul_b = HASH_MULT;
        if (state_reg == ST_MOD) begin
            case (cnt_reg)
                MOD_LO: begin
                    mul_a = prod_reg;
                    mul_b = RECIP_LO;
                end
                MOD_HI: begin
                    mul_a = prod_reg;
                    mul_b = RECIP_HI;
                end
                default: begin
                    mul_a = acc_reg[KEY_W-1:0];
                    mul_b = N_K;
                end
            endcase
        end
    end

    assign mul_p      = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign product    = mul_p[KEY_W-1:0];
    assign rem_fix    = (acc_reg[KEY_W-1:0] >= N_K) ? (acc_reg[KEY_W-1:0] - N_K)
                                                    : acc_reg[KEY_W-1:0];
    assign slot_valid = (ram_rd_data[WORD_W-1:KEY_W] == epoch_reg);
    assign key_match  = (ram_rd_data[KEY_W-1:0] == key_reg);
    assign emit_ok    = !m_valid_reg || m_ready;
    assign idx_inc    = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == IDX_LAST) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_HASH;
            end
            ST_HASH: begin
                state_next = IS_POW2 ? ST_READ : ST_MOD;
            end
            ST_MOD: begin
                if (cnt_reg == MOD_FIX) state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!slot_valid || key_match || step_reg == IDX_LAST) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_DONE: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (emit_ok) begin
                    state_next = (epoch_reg == EPOCH_MAX) ? ST_CLEAR : ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready     = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = {epoch_reg, key_reg};
        ram_rd_en   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                ram_wr_data = '0;
            end
            ST_IDLE:  s_ready   = 1'b1;
            ST_READ:  ram_rd_en = 1'b1;
            ST_CHECK: ram_wr_en = !slot_valid;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        key_next     = key_reg;
        last_next    = last_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        clr_next     = clr_reg;
        epoch_next   = epoch_reg;
        found_next   = found_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_dup_next   = m_dup_reg;
        m_ovf_next   = m_ovf_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_next = (clr_reg == IDX_LAST) ? '0 : clr_reg + 1'b1;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    key_next  = s_value;
                    last_next = s_last;
                end
            end
            ST_HASH: begin
                prod_next = product;
                idx_next  = product[IW-1:0];
                cnt_next  = MOD_LO;
                step_next = '0;
            end
            ST_MOD: begin
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg)
                    MOD_LO:  acc_next = mul_p >> 16;
                    MOD_HI:  acc_next = (acc_reg + mul_p) >> Q_SHIFT;
                    MOD_MUL: acc_next = {{KEY_W{1'b0}}, prod_reg - mul_p[KEY_W-1:0]};
                    default: idx_next = rem_fix[IW-1:0];
                endcase
            end
            ST_CHECK: begin
                if (slot_valid) begin
                    if (key_match) begin
                        found_next = 1'b1;
                    end else if (step_reg == IDX_LAST) begin
                        ovf_next = 1'b1;
                    end else begin
                        idx_next  = idx_inc;
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (last_reg && emit_ok) begin
                    m_valid_next = 1'b1;
                    m_dup_next   = found_reg;
                    m_ovf_next   = ovf_reg;
                    found_next   = 1'b0;
                    ovf_next     = 1'b0;
                    epoch_next   = (epoch_reg == EPOCH_MAX) ? EPOCH_FIRST
                                                            : epoch_reg + 1'b1;
                end
            end
            default: begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            epoch_reg   <= EPOCH_FIRST;
            found_reg   <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            epoch_reg   <= epoch_next;
            found_reg   <= found_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
        key_reg   <= key_next;
        last_reg  <= last_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        step_reg  <= step_next;
        m_dup_reg <= m_dup_next;
        m_ovf_reg <= m_ovf_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_has_duplicate  = m_dup_reg;
    assign m_table_overflow = m_ovf_reg;

endmodule

@@ tb/sv/stream_duplicate_detector_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_duplicate_detector_top_test: self-checking bench for the detector
// Streams arrays of signed words with random sender bursts and receiver
// stalls, tracks the hash set on the side and checks every verdict in order.
// ----------------------------------------------------------------------------
module stream_duplicate_detector_top_test
    import sdd_pkg::*;
();

    localparam int unsigned SLOT_COUNT   = TABLE_ENTRIES_DEF;
    localparam logic [31:0] FIB_MULT     = 32'h9E37_79B1;
    localparam int unsigned RANDOM_ITEMS = 380;
    localparam int unsigned DRAIN_LIMIT  = 200000;

    typedef struct packed {
        logic dup;
        logic ovf;
    } verdict_t;

    typedef enum int unsigned {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE
    } rx_mode_t;

    typedef enum int unsigned {
        ARR_POOL,
        ARR_DISTINCT,
        ARR_CHAIN
    } array_kind_t;

    logic                    aclk             = 1'b0;
    logic                    aresetn          = 1'b0;
    logic signed [KEY_W-1:0] s_value          = '0;
    logic                    s_last           = 1'b0;
    logic                    s_valid          = 1'b0;
    logic                    s_ready;
    logic                    m_has_duplicate;
    logic                    m_table_overflow;
    logic                    m_valid;
    logic                    m_ready          = 1'b0;

    bit [31:0]   set_keys [SLOT_COUNT];
    bit          set_used [SLOT_COUNT];
    bit          dup_seen;
    bit          ovf_seen;
    verdict_t    pending_verdicts[$];

    int unsigned burst_left;
    int unsigned hold_off_cycles;
    int unsigned items_sent;
    int unsigned verdicts_seen;
    int unsigned dup_verdicts;
    int unsigned ovf_verdicts;
    int unsigned fail_count;

    stream_duplicate_detector_top #(
        .TABLE_ENTRIES(SLOT_COUNT)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_value         (s_value),
        .s_last          (s_last),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .m_has_duplicate (m_has_duplicate),
        .m_table_overflow(m_table_overflow),
        .m_valid         (m_valid),
        .m_ready         (m_ready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int unsigned slot_index(input bit [31:0] key);
        bit [31:0] mixed;
        mixed = key * FIB_MULT;
        return mixed % SLOT_COUNT;
    endfunction

    // insert into the shadow set; emit a verdict and clear on the final element
    function automatic void absorb_element(input bit [31:0] key, input bit is_last);
        int unsigned idx;
        int unsigned step;
        bit          placed;
        verdict_t    verdict;
        idx    = slot_index(key);
        placed = 1'b0;
        for (step = 0; step < SLOT_COUNT && !placed; step++) begin
            if (!set_used[idx]) begin
                set_used[idx] = 1'b1;
                set_keys[idx] = key;
                placed        = 1'b1;
            end else if (set_keys[idx] == key) begin
                dup_seen = 1'b1;
                placed   = 1'b1;
            end else begin
                idx = (idx + 1) % SLOT_COUNT;
            end
        end
        if (!placed) begin
            ovf_seen = 1'b1;
        end
        if (is_last) begin
            verdict.dup = dup_seen;
            verdict.ovf = ovf_seen;
            pending_verdicts.push_back(verdict);
            set_used = '{default: 1'b0};
            dup_seen = 1'b0;
            ovf_seen = 1'b0;
        end
    endfunction

    task automatic send_element(input logic [31:0] value, input bit is_last);
        s_value <= value;
        s_last  <= is_last;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        absorb_element(value, is_last);
        items_sent++;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 5);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain_requests();
        int unsigned waited;
        s_valid <= 1'b0;
        waited = 0;
        while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_verdicts.size() != 0) begin
            $error("%0d verdicts never arrived", pending_verdicts.size());
            fail_count++;
        end
    endtask

    // receiver: changing stall pattern, or a counted hold-off when requested
    initial begin : receiver
        rx_mode_t    mode;
        int unsigned mode_left;
        mode      = RX_OPEN;
        mode_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_cycles != 0) begin
                m_ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    RX_OPEN: begin
                        m_ready <= 1'b1;
                    end
                    RX_COIN: begin
                        m_ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        m_ready <= ($urandom_range(0, 9) == 0);
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin : check_results
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result with no array pending: has_duplicate=%0b table_overflow=%0b",
                       m_has_duplicate, m_table_overflow);
                fail_count++;
            end else begin
                want = pending_verdicts.pop_front();
                verdicts_seen++;
                if (want.dup) dup_verdicts++;
                if (want.ovf) ovf_verdicts++;
                if (m_has_duplicate !== want.dup) begin
                    $error("has_duplicate: expected %0b, got %0b", want.dup, m_has_duplicate);
                    fail_count++;
                end
                if (m_table_overflow !== want.ovf) begin
                    $error("table_overflow: expected %0b, got %0b", want.ovf,
                           m_table_overflow);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_single_element();
        send_element(32'h8000_0000, 1'b1);
        send_element(32'h7FFF_FFFF, 1'b1);
        drain_requests();
    endtask

    task automatic test_extremes();
        send_element(32'h7FFF_FFFF, 1'b0);
        send_element(32'h8000_0000, 1'b0);
        send_element(32'h0000_0000, 1'b0);
        send_element(32'hFFFF_FFFF, 1'b0);
        send_element(32'h8000_0000, 1'b1);
        send_element(32'h0000_0001, 1'b0);
        send_element(32'h0000_0002, 1'b0);
        send_element(32'hFFFF_FFFE, 1'b1);
        drain_requests();
    endtask

    // chain through the top slot so the probe wraps to slot zero
    task automatic test_probe_wrap();
        logic [31:0] base;
        base = '0;
        while (slot_index(base) != SLOT_COUNT - 1) base++;
        send_element(base, 1'b0);
        send_element(base + SLOT_COUNT, 1'b0);
        send_element(base + 2 * SLOT_COUNT, 1'b0);
        send_element(base + 3 * SLOT_COUNT, 1'b0);
        send_element(base + 2 * SLOT_COUNT, 1'b1);
        drain_requests();
    endtask

    // duplicate flag holds through later elements, then clears for the next array
    task automatic test_flag_persistence();
        send_element(32'd5, 1'b0);
        send_element(32'd5, 1'b0);
        send_element(32'd6, 1'b0);
        send_element(32'd7, 1'b1);
        send_element(32'd6, 1'b1);
        drain_requests();
    endtask

    // consecutive keys fill every slot once; the next colliding key overflows
    task automatic test_overflow();
        logic [31:0] base;
        int unsigned k;
        base = $urandom;
        for (k = 0; k < SLOT_COUNT; k++) begin
            send_element(base + k, 1'b0);
        end
        send_element(base + SLOT_COUNT, 1'b0);
        send_element(base + 5, 1'b0);
        send_element(base + SLOT_COUNT + 1, 1'b1);
        drain_requests();
    endtask

    // hold the result channel off long enough for the input to back up
    task automatic test_output_backpressure();
        int unsigned n;
        int unsigned len;
        int unsigned k;
        hold_off_cycles = 600;
        for (n = 0; n < 12; n++) begin
            len = $urandom_range(1, 3);
            for (k = 0; k < len; k++) begin
                send_element($urandom_range(0, 3), k == len - 1);
            end
        end
        drain_requests();
    endtask

    task automatic test_random_arrays();
        logic [31:0] pool [16];
        logic [31:0] value;
        logic [31:0] base;
        array_kind_t kind;
        int unsigned start;
        int unsigned len;
        int unsigned pool_size;
        int unsigned pick;
        int unsigned k;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                len = $urandom_range(1, 6);
            end else if (pick < 19) begin
                len = $urandom_range(7, 40);
            end else begin
                len = $urandom_range(41, 150);
            end
            kind      = array_kind_t'($urandom_range(0, 2));
            pool_size = $urandom_range(1, (len < 16) ? len : 16);
            for (k = 0; k < 16; k++) begin
                pool[k] = $urandom;
            end
            base = $urandom;
            for (k = 0; k < len; k++) begin
                case (kind)
                    ARR_POOL: begin
                        value = pool[$urandom_range(0, pool_size - 1)];
                    end
                    ARR_DISTINCT: begin
                        value = $urandom;
                    end
                    default: begin
                        value = base + SLOT_COUNT * $urandom_range(0, 7);
                    end
                endcase
                send_element(value, k == len - 1);
            end
        end
        drain_requests();
    endtask

    initial begin
        set_used = '{default: 1'b0};
        dup_seen = 1'b0;
        ovf_seen = 1'b0;
        burst_left      = 0;
        hold_off_cycles = 0;
        items_sent      = 0;
        verdicts_seen   = 0;
        dup_verdicts    = 0;
        ovf_verdicts    = 0;
        fail_count      = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_single_element();
        test_extremes();
        test_probe_wrap();
        test_flag_persistence();
        test_overflow();
        test_output_backpressure();
        test_random_arrays();
        repeat (64) @(posedge aclk);
        $display("Streamed %0d elements forming %0d arrays.", items_sent, verdicts_seen);
        $display("Verdicts with a repeat: %0d, with the table overflowed: %0d.",
                 dup_verdicts, ovf_verdicts);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
